// File: src/area_average_image_downscaler_macros.svh
// ----------------------------------------------------------------------------
// Area-average downscaler assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef AREA_AVERAGE_IMAGE_DOWNSCALER_MACROS_SVH
`define AREA_AVERAGE_IMAGE_DOWNSCALER_MACROS_SVH

// Same-cycle implication.
`define ADS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ads_pkg.sv
// ----------------------------------------------------------------------------
// Area-average downscaler package
// Widths, state and register codes, and the interval overlap helper.
// ----------------------------------------------------------------------------
package ads_pkg;

    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int IN_CHANNELS      = 4;
    localparam int CHAN_W           = 8;
    localparam int SUM_W            = 32;
    localparam int SZ_W             = 14;   // effective size values
    localparam int ROW_IDX_W        = 12;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int MUL_W            = 14;
    localparam int POS_W            = 2 * MUL_W;
    localparam int WGT_W            = 13;
    localparam int WP_W             = 2 * WGT_W;
    localparam int CFG_IDX_W        = 3;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [WGT_W-1:0] wgt_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3,
        ST_WGT, ST_PROD, ST_COL0, ST_COL1, ST_COL2
    } ads_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH,
        CFG_DST_HEIGHT, CFG_CHAN_COUNT, CFG_AREA_RECIP
    } ads_cfg_idx_t;

    // Length of the intersection of [a0,a1) and [b0,b1).
    function automatic wgt_t overlap(pos_t a0, pos_t a1, pos_t b0, pos_t b1);
        pos_t lo;
        pos_t hi;
        pos_t diff;
        lo   = (a0 > b0) ? a0 : b0;
        hi   = (a1 < b1) ? a1 : b1;
        diff = (hi > lo) ? (hi - lo) : '0;
        return diff[WGT_W-1:0];
    endfunction

endpackage

// File: src/ads_line_ram.sv
// ----------------------------------------------------------------------------
// Accumulator line RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ads_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 128
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/area_average_image_downscaler.sv
// ----------------------------------------------------------------------------
// Area-average image downscaler
// Raster-order area-averaging scaler built around two accumulator line RAMs.
// ----------------------------------------------------------------------------
// Each source pixel passes, from its acceptance to the earliest acceptance of
// the next one, through the steps MUL0 to MUL3 on one shared 14x14 multiplier
// for the interval edges, WGT for the overlaps, PROD for the weight
// products, then a read-modify-write pass over the two touched destination
// columns in the current-row and next-row RAMs (one read and one write port
// each), and the idle step that takes the next pixel. A result waiting in the
// output register stalls only the final step, and only when a new result is due.
// After reset the block sweeps both RAMs to zero, one column per cycle, with
// s_tready low; configuration writes are taken at any time but must only be
// issued while the block is idle.
module area_average_image_downscaler #(
    parameter int MAX_WIDTH    = ads_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = ads_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    // source pixels
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // chan0_in, chan1_in, chan2_in, chan3_in
    // destination pixels
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // chan0_out, chan1_out, chan2_out, chan3_out
    output logic                              m_tlast,   // row_end
    output logic [0:0]                        m_tuser    // frame_end
);

    import ads_pkg::*;

    localparam int IDX_W  = $clog2(MAX_WIDTH);
    localparam int LINE_W = MAX_CHANNELS * SUM_W;

    // ---------------- configuration ----------------
    logic [11:0] src_w_reg;
    logic [12:0] src_h_reg;
    logic [11:0] dst_w_reg;
    logic [12:0] dst_h_reg;
    logic [2:0]  chan_cnt_reg;
    logic [31:0] recip_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg    <= 12'd640;
            src_h_reg    <= 13'd480;
            dst_w_reg    <= 12'd320;
            dst_h_reg    <= 13'd240;
            chan_cnt_reg <= 3'd3;
            recip_reg    <= '0;
        end else if (cfg_valid) begin
            case (ads_cfg_idx_t'(cfg_index))
                CFG_SRC_WIDTH:  src_w_reg    <= cfg_data[11:0];
                CFG_SRC_HEIGHT: src_h_reg    <= cfg_data[12:0];
                CFG_DST_WIDTH:  dst_w_reg    <= cfg_data[11:0];
                CFG_DST_HEIGHT: dst_h_reg    <= cfg_data[12:0];
                CFG_CHAN_COUNT: chan_cnt_reg <= cfg_data[2:0];
                CFG_AREA_RECIP: recip_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp sizes: width to [1, MAX_WIDTH], height to [1, 4096],
    // destination to [1, source], channels to [1, MAX_CHANNELS].
    logic [SZ_W-1:0] sw, sh, dw, dh;
    logic [2:0]      cc;

    always_comb begin
        sw = SZ_W'(src_w_reg);
        if (sw == '0) sw = SZ_W'(1);
        else if (sw > SZ_W'(MAX_WIDTH)) sw = SZ_W'(MAX_WIDTH);
        sh = SZ_W'(src_h_reg);
        if (sh == '0) sh = SZ_W'(1);
        else if (sh > SZ_W'(HEIGHT_LIMIT)) sh = SZ_W'(HEIGHT_LIMIT);
        dw = SZ_W'(dst_w_reg);
        if (dw == '0) dw = SZ_W'(1);
        else if (dw > sw) dw = sw;
        dh = SZ_W'(dst_h_reg);
        if (dh == '0) dh = SZ_W'(1);
        else if (dh > sh) dh = sh;
        cc = chan_cnt_reg;
        if (cc == '0) cc = 3'd1;
        else if (cc > 3'(MAX_CHANNELS)) cc = 3'(MAX_CHANNELS);
    end

    // ---------------- state ----------------
    ads_state_t state_reg, state_next;

    logic [IDX_W-1:0]     clr_addr_reg;
    logic [IDX_W-1:0]     sc_reg, dc_reg;
    logic [ROW_IDX_W-1:0] sr_reg, dr_reg;
    logic [31:0]          pix_reg;

    pos_t xa0_reg, xb0_reg, ya0_reg, yb0_reg;
    wgt_t wxc_reg, wxn_reg, wyc_reg, wyn_reg;
    logic [WP_W-1:0] wcc_reg, wcn_reg, wnc_reg, wnn_reg;
    logic col_done_reg, row_done_reg, last_col_reg, last_row_reg;
    logic dc_lt_reg, dc1_lt_reg, dr1_lt_reg, emit_reg;
    logic row_end_reg, frame_end_reg;

    logic [SUM_W-1:0] cur_sum_reg   [MAX_CHANNELS];
    logic [SUM_W-1:0] nxt_sum_reg   [MAX_CHANNELS];
    logic [SUM_W-1:0] scale_reg     [MAX_CHANNELS];
    logic [SUM_W-1:0] cur_sum_next  [MAX_CHANNELS];
    logic [SUM_W-1:0] nxt_sum_next  [MAX_CHANNELS];
    logic [SUM_W-1:0] scale_next    [MAX_CHANNELS];

    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg, out_frame_reg;
    logic        out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_frame_reg;

    // ---------------- line RAMs ----------------
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINE_W-1:0] cur_rd, nxt_rd, cur_wr, nxt_wr;

    ads_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(LINE_W)) u_cur_line (
        .aclk(aclk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(cur_rd),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(cur_wr)
    );

    ads_line_ram #(.DEPTH(MAX_WIDTH), .DATA_W(LINE_W)) u_nxt_line (
        .aclk(aclk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(nxt_rd),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(nxt_wr)
    );

    // ---------------- shared edge multiplier ----------------
    logic [MUL_W-1:0] mul_a, mul_b;
    pos_t             mul_p;

    always_comb begin
        case (state_reg)
            ST_MUL0: begin mul_a = MUL_W'(sc_reg); mul_b = MUL_W'(dw); end
            ST_MUL1: begin mul_a = MUL_W'(dc_reg); mul_b = MUL_W'(sw); end
            ST_MUL2: begin mul_a = MUL_W'(sr_reg); mul_b = MUL_W'(dh); end
            default: begin mul_a = MUL_W'(dr_reg); mul_b = MUL_W'(sh); end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Interval ends from the registered starts.
    pos_t xa1, xb1, xb2, ya1, yb1, yb2;
    logic [SZ_W-1:0] dc_p1, sc_p1, dr_p1, sr_p1;

    assign xa1   = xa0_reg + POS_W'(dw);
    assign xb1   = xb0_reg + POS_W'(sw);
    assign xb2   = xb1 + POS_W'(sw);
    assign ya1   = ya0_reg + POS_W'(dh);
    assign yb1   = yb0_reg + POS_W'(sh);
    assign yb2   = yb1 + POS_W'(sh);
    assign dc_p1 = SZ_W'(dc_reg) + SZ_W'(1);
    assign sc_p1 = SZ_W'(sc_reg) + SZ_W'(1);
    assign dr_p1 = SZ_W'(dr_reg) + SZ_W'(1);
    assign sr_p1 = SZ_W'(sr_reg) + SZ_W'(1);

    // ---------------- per-channel lanes ----------------
    logic [WP_W-1:0]      w_cur, w_nxt;
    logic [LINE_W-1:0]    lane_cur, lane_nxt;

    assign w_cur    = (state_reg == ST_COL0) ? wcc_reg : wnc_reg;
    assign w_nxt    = (state_reg == ST_COL0) ? wcn_reg : wnn_reg;
    assign lane_cur = cur_rd;
    assign lane_nxt = nxt_rd;

    always_comb begin
        logic [CHAN_W+WP_W-1:0] add_c, add_n;
        logic [2*SUM_W-1:0]     prod;
        logic [CHAN_W-1:0]      px;
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            px    = pix_reg[ch*CHAN_W +: CHAN_W];
            add_c = (3'(ch) < cc) ? (px * w_cur) : '0;
            add_n = (3'(ch) < cc) ? (px * w_nxt) : '0;
            cur_sum_next[ch] = lane_cur[ch*SUM_W +: SUM_W] + add_c[SUM_W-1:0];
            nxt_sum_next[ch] = lane_nxt[ch*SUM_W +: SUM_W] + add_n[SUM_W-1:0];
            prod             = cur_sum_reg[ch] * recip_reg;
            scale_next[ch]   = prod[2*SUM_W-1:SUM_W];
        end
    end

    // RAM write data: emission moves the next-row sum up and clears it.
    always_comb begin
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            if (state_reg == ST_CLEAR) begin
                cur_wr[ch*SUM_W +: SUM_W] = '0;
                nxt_wr[ch*SUM_W +: SUM_W] = '0;
            end else if (state_reg == ST_COL1 && emit_reg) begin
                cur_wr[ch*SUM_W +: SUM_W] = nxt_sum_reg[ch];
                nxt_wr[ch*SUM_W +: SUM_W] = '0;
            end else begin
                cur_wr[ch*SUM_W +: SUM_W] = cur_sum_reg[ch];
                nxt_wr[ch*SUM_W +: SUM_W] = nxt_sum_reg[ch];
            end
        end
    end

    // Saturated output channels; channels past the count read zero.
    logic [31:0] out_pack;

    always_comb begin
        out_pack = '0;
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            if (3'(ch) < cc) begin
                out_pack[ch*CHAN_W +: CHAN_W] =
                    (scale_reg[ch] > SUM_W'(255)) ? 8'hFF : scale_reg[ch][CHAN_W-1:0];
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = dc_reg;
        wr_en      = 1'b0;
        wr_addr    = dc_reg;
        case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(MAX_WIDTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MUL0;
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_WGT;
            ST_WGT:  state_next = ST_PROD;
            ST_PROD: begin
                rd_en      = 1'b1;
                state_next = ST_COL0;
            end
            ST_COL0: begin
                rd_en      = 1'b1;
                rd_addr    = dc_p1[IDX_W-1:0];
                state_next = ST_COL1;
            end
            ST_COL1: begin
                wr_en      = dc_lt_reg;
                state_next = ST_COL2;
            end
            ST_COL2: begin
                wr_en   = dc1_lt_reg;
                wr_addr = dc_p1[IDX_W-1:0];
                if (!emit_reg || out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            sc_reg        <= '0;
            dc_reg        <= '0;
            sr_reg        <= '0;
            dr_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR && clr_addr_reg != IDX_W'(MAX_WIDTH - 1)) begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            end
            // load a new result, or drop the one taken by the sink
            if (state_reg == ST_COL2 && emit_reg && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_COL2 && (!emit_reg || out_free)) begin
                // advance the source and destination counters
                if (last_col_reg) begin
                    sc_reg <= '0;
                    dc_reg <= '0;
                    if (last_row_reg) begin
                        sr_reg <= '0;
                        dr_reg <= '0;
                    end else begin
                        sr_reg <= sr_p1[ROW_IDX_W-1:0];
                        if (row_done_reg && dr1_lt_reg) dr_reg <= dr_p1[ROW_IDX_W-1:0];
                    end
                end else begin
                    sc_reg <= sc_p1[IDX_W-1:0];
                    if (col_done_reg && dc1_lt_reg) dc_reg <= dc_p1[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: pix_reg <= s_tdata;
            ST_MUL0: xa0_reg <= mul_p;
            ST_MUL1: xb0_reg <= mul_p;
            ST_MUL2: ya0_reg <= mul_p;
            ST_MUL3: yb0_reg <= mul_p;
            ST_WGT: begin
                wxc_reg       <= overlap(xa0_reg, xa1, xb0_reg, xb1);
                wxn_reg       <= overlap(xa0_reg, xa1, xb1, xb2);
                wyc_reg       <= overlap(ya0_reg, ya1, yb0_reg, yb1);
                // no next destination row below the last one
                wyn_reg       <= (dr_p1 >= dh) ? '0 : overlap(ya0_reg, ya1, yb1, yb2);
                col_done_reg  <= (xa1 >= xb1);
                row_done_reg  <= (ya1 >= yb1);
                last_col_reg  <= (sc_p1 >= sw);
                last_row_reg  <= (sr_p1 >= sh);
                dc_lt_reg     <= (SZ_W'(dc_reg) < dw);
                dc1_lt_reg    <= (dc_p1 < dw);
                dr1_lt_reg    <= (dr_p1 < dh);
                emit_reg      <= (xa1 >= xb1) && (ya1 >= yb1)
                                 && (SZ_W'(dc_reg) < dw) && (SZ_W'(dr_reg) < dh);
                row_end_reg   <= (dc_p1 == dw);
                frame_end_reg <= (dc_p1 == dw) && (dr_p1 == dh);
            end
            ST_PROD: begin
                wcc_reg <= wxc_reg * wyc_reg;
                wcn_reg <= wxc_reg * wyn_reg;
                wnc_reg <= wxn_reg * wyc_reg;
                wnn_reg <= wxn_reg * wyn_reg;
            end
            ST_COL0: begin
                cur_sum_reg <= cur_sum_next;
                nxt_sum_reg <= nxt_sum_next;
            end
            ST_COL1: begin
                // scale the finished sum while the second column is summed
                scale_reg   <= scale_next;
                cur_sum_reg <= cur_sum_next;
                nxt_sum_reg <= nxt_sum_next;
            end
            ST_COL2: begin
                if (emit_reg && out_free) begin
                    out_data_reg  <= out_pack;
                    out_last_reg  <= row_end_reg;
                    out_frame_reg <= frame_end_reg;
                end
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
`include "area_average_image_downscaler_macros.svh"

    `ADS_ASSERT_NOW(a_accept_after_clear, s_tvalid && s_tready, clr_addr_reg == IDX_W'(MAX_WIDTH - 1), "pixel accepted before line clear finished")
    `ADS_ASSERT_NOW(a_load_from_col2, $rose(out_valid_reg), $past(state_reg == ST_COL2) && $past(emit_reg), "result loaded outside emission step")
    `ADS_ASSERT_NEXT(a_hold_on_full, state_reg == ST_COL2 && emit_reg && !out_free, state_reg == ST_COL2, "sequencer left emission with output full")
    `ADS_ASSERT_NOW(a_no_write_past_width, state_reg == ST_COL2 && wr_en, dc_p1 < dw, "second column written past destination width")

endmodule
